FILE: rtl/gde_pkg.sv
// Shared constants, types and elaboration-time helpers for the Gaussian density unit.
// No dependencies; every other file of the block imports this package.
package gde_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // Exponent argument t = (y-mu)^2/(2v) in Q.32, limited below 2^37
  localparam int T_BITS  = 37;
  localparam int T_SHIFT = FRAC_BITS - 1;
  localparam int SQ_W    = 2 * DATA_WIDTH;
  localparam int LO_W    = T_BITS - T_SHIFT;
  localparam int HI_W    = SQ_W - LO_W;

  localparam int L2E_W = 33;
  localparam logic [L2E_W-1:0] LOG2E_Q32 = 33'h1_7154_7653;
  localparam int FR_W  = 32;
  localparam int ACC_W = FR_W + 1;
  localparam int N_W   = 6;

  localparam int TWOPI_W = 15;
  localparam logic [TWOPI_W-1:0] TWO_PI_Q12 = 15'd25736;
  localparam int X_W       = 64;
  localparam int M_W       = 5;
  localparam int ROOT_W    = 32;
  localparam int NORM_STEPS = 5;

  localparam int S_W    = 8;
  localparam int DENS_W = 32;
  localparam logic [DENS_W-1:0] DENS_MAX = '1;

  // Pipeline depths of each unit, in register stages
  localparam int RATIO_LAT = 3 + T_BITS;
  localparam int EXP_LAT   = 2 + FR_W;
  localparam int ROOT_LAT  = 1 + NORM_STEPS + ROOT_W;
  localparam int QUOT_LAT  = 4 + DENS_W;
  localparam int ROOT_DLY  = RATIO_LAT + EXP_LAT - ROOT_LAT;
  localparam int TOTAL_LAT = RATIO_LAT + EXP_LAT + QUOT_LAT;

  typedef struct packed {
    logic valid;
    logic bad;
    logic kill;
  } flags_t;

  // Floor square root, used only to build constants
  function automatic logic [63:0] isqrt_c(input logic [63:0] x);
    logic [65:0] rem;
    logic [65:0] trial;
    logic [63:0] root;
    rem  = '0;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      rem   = {rem[63:0], x[2*b +: 2]};
      trial = {root, 2'b01};
      if (rem >= trial) begin
        rem  = rem - trial;
        root = {root[62:0], 1'b1};
      end else begin
        root = {root[62:0], 1'b0};
      end
    end
    return root;
  endfunction

  // 2^(-2^-k) in Q.32, by k repeated square roots of one half
  function automatic logic [31:0] exp_root_c(input int k);
    logic [63:0] c;
    c = 64'h8000_0000;
    for (int j = 0; j < k; j++) begin
      c = isqrt_c({c[31:0], 32'h0});
    end
    return c[31:0];
  endfunction

endpackage

FILE: rtl/gaussian_density_eval_unit.sv
// Top level of the Gaussian density unit: pipeline of ratio, exp2, root and quotient units.
// Depends on gde_pkg, gde_ratio, gde_exp2, gde_root and gde_quot.
//
//   Channel   Direction  Beat marker        Payload
//   command   in         start_i & !busy_o  observation_i, mean_i, variance_i
//   result    out        done_o             density_o, bad_variance_o, saturated_o
//
// One beat enters per cycle; busy_o never rises.
// Between a command beat and its result lie TOTAL_LAT register stages: 40 stages
// for the squared-difference division, 34 for the exp2 multiplier chain, 36 for the
// final rounding division. The variance square root runs alongside in 38 stages and
// waits in a 36-deep delay line.
// Reset clears only the flag registers; payload registers carry whatever they held.
// The receiver cannot stall, so the pipeline never holds.
module gaussian_density_eval_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [gde_pkg::DATA_WIDTH-1:0]  observation_i,
  input  logic [gde_pkg::DATA_WIDTH-1:0]  mean_i,
  input  logic [gde_pkg::DATA_WIDTH-1:0]  variance_i,
  output logic                            done_o,
  output logic [gde_pkg::DENS_W-1:0]      density_o,
  output logic                            bad_variance_o,
  output logic                            saturated_o
);
  import gde_pkg::*;

  flags_t            rat_flags, exp_flags;
  logic [T_BITS-1:0] t;
  logic [ACC_W-1:0]  acc;
  logic [N_W-1:0]    n;
  logic [ROOT_W-1:0] r;
  logic [M_W-1:0]    m;

  // Delay line that lines up the variance root with its own item
  logic [ROOT_W-1:0] r_dly_q [0:ROOT_DLY-1];
  logic [M_W-1:0]    m_dly_q [0:ROOT_DLY-1];

  // Fully pipelined: never refuse a beat
  assign busy_o = 1'b0;

  gde_ratio u_ratio (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (start_i),
    .obs_i      (observation_i),
    .mean_i     (mean_i),
    .var_i      (variance_i),
    .flags_o    (rat_flags),
    .t_o        (t)
  );

  gde_exp2 u_exp2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (rat_flags),
    .t_i     (t),
    .flags_o (exp_flags),
    .acc_o   (acc),
    .n_o     (n)
  );

  gde_root u_root (
    .clk_i (clk_i),
    .var_i (variance_i),
    .r_o   (r),
    .m_o   (m)
  );

  // Advance the root and its shift count in step with the main chain
  always_ff @(posedge clk_i) begin
    r_dly_q[0] <= r;
    m_dly_q[0] <= m;
    for (int i = 1; i < ROOT_DLY; i++) begin
      r_dly_q[i] <= r_dly_q[i-1];
      m_dly_q[i] <= m_dly_q[i-1];
    end
  end

  gde_quot u_quot (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .flags_i   (exp_flags),
    .acc_i     (acc),
    .n_i       (n),
    .r_i       (r_dly_q[ROOT_DLY-1]),
    .m_i       (m_dly_q[ROOT_DLY-1]),
    .done_o    (done_o),
    .density_o (density_o),
    .bad_o     (bad_variance_o),
    .sat_o     (saturated_o)
  );

  // Every command beat yields its result after the fixed pipeline depth
  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##TOTAL_LAT done_o)
    else $error("result beat missing after command beat");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bad_variance_o |-> (density_o == '0) && !saturated_o)
    else $error("zero variance gave nonzero density or saturation");

  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    saturated_o |-> (density_o == DENS_MAX) && !bad_variance_o)
    else $error("saturated result not clamped");

  a_flags_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> !bad_variance_o && !saturated_o)
    else $error("flag raised without a result beat");

endmodule

FILE: rtl/gde_ratio.sv
// Difference, square and bit-per-stage division giving t = (y-mu)^2/(2v) in Q.32.
// Depends on gde_pkg.
module gde_ratio (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic [gde_pkg::DATA_WIDTH-1:0]  obs_i,
  input  logic [gde_pkg::DATA_WIDTH-1:0]  mean_i,
  input  logic [gde_pkg::DATA_WIDTH-1:0]  var_i,
  output gde_pkg::flags_t                 flags_o,
  output logic [gde_pkg::T_BITS-1:0]      t_o
);
  import gde_pkg::*;

  logic [DATA_WIDTH:0]   diff;
  logic [DATA_WIDTH:0]   mag;
  logic [DATA_WIDTH-1:0] a0_q, v0_q, v1_q;
  flags_t                f0_q, f1_q;
  logic [SQ_W-1:0]       sq1_q;
  logic                  tail;

  logic [DATA_WIDTH:0]   rem_q [0:T_BITS];
  logic [T_BITS-1:0]     q_q   [0:T_BITS];
  logic [DATA_WIDTH-1:0] v_q   [0:T_BITS];
  logic [LO_W-1:0]       lo_q  [0:T_BITS];
  flags_t                f_q   [0:T_BITS];

  assign diff = {obs_i[DATA_WIDTH-1], obs_i} - {mean_i[DATA_WIDTH-1], mean_i};
  assign mag  = diff[DATA_WIDTH] ? (~diff + 1'b1) : diff;
  assign tail = sq1_q[SQ_W-1:LO_W] >= HI_W'(v1_q);

  always_ff @(posedge clk_i) begin
    a0_q     <= mag[DATA_WIDTH-1:0];
    v0_q     <= var_i;
    sq1_q    <= SQ_W'(a0_q) * SQ_W'(a0_q);
    v1_q     <= v0_q;
    rem_q[0] <= {1'b0, sq1_q[LO_W+DATA_WIDTH-1:LO_W]};
    q_q[0]   <= '0;
    v_q[0]   <= v1_q;
    lo_q[0]  <= sq1_q[LO_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0_q   <= '0;
      f1_q   <= '0;
      f_q[0] <= '0;
    end else begin
      f0_q   <= '{valid: in_valid_i, bad: (var_i == '0), kill: (var_i == '0)};
      f1_q   <= f0_q;
      f_q[0] <= '{valid: f1_q.valid, bad: f1_q.bad, kill: (f1_q.kill | tail)};
    end
  end

  for (genvar j = 0; j < T_BITS; j++) begin : g_div
    localparam int B = T_BITS - 1 - j;
    logic                nb;
    logic [DATA_WIDTH:0] rin;
    logic                ge;

    if (B >= T_SHIFT) begin : g_bit
      assign nb = lo_q[j][B-T_SHIFT];
    end else begin : g_zero
      assign nb = 1'b0;
    end

    assign rin = {rem_q[j][DATA_WIDTH-1:0], nb};
    assign ge  = rin >= {1'b0, v_q[j]};

    always_ff @(posedge clk_i) begin
      rem_q[j+1] <= ge ? (rin - {1'b0, v_q[j]}) : rin;
      q_q[j+1]   <= {q_q[j][T_BITS-2:0], ge};
      v_q[j+1]   <= v_q[j];
      lo_q[j+1]  <= lo_q[j];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        f_q[j+1] <= '0;
      end else begin
        f_q[j+1] <= f_q[j];
      end
    end
  end

  assign flags_o = f_q[T_BITS];
  assign t_o     = q_q[T_BITS];

endmodule

FILE: rtl/gde_exp2.sv
// Scales t by log2(e) and forms 2^-frac with one constant multiply per stage.
// Depends on gde_pkg.
module gde_exp2 (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gde_pkg::flags_t              flags_i,
  input  logic [gde_pkg::T_BITS-1:0]   t_i,
  output gde_pkg::flags_t              flags_o,
  output logic [gde_pkg::ACC_W-1:0]    acc_o,
  output logic [gde_pkg::N_W-1:0]      n_o
);
  import gde_pkg::*;

  localparam int P0_W = FR_W + L2E_W;
  localparam int P1_W = (T_BITS - FR_W) + L2E_W;
  localparam int PR_W = 2 * FR_W + 1;

  logic [P0_W-1:0] p0_q;
  logic [P1_W-1:0] p1_q;
  flags_t          fm_q;
  logic [P1_W-1:0] u;

  logic [ACC_W-1:0] acc_q [0:FR_W];
  logic [FR_W-1:0]  f_q   [0:FR_W];
  logic [N_W-1:0]   n_q   [0:FR_W];
  flags_t           fl_q  [0:FR_W];

  // Sum of the two partial products, shifted down by 32
  assign u = p1_q + P1_W'(p0_q[P0_W-1:FR_W]);

  always_ff @(posedge clk_i) begin
    p0_q     <= P0_W'(t_i[FR_W-1:0]) * P0_W'(LOG2E_Q32);
    p1_q     <= P1_W'(t_i[T_BITS-1:FR_W]) * P1_W'(LOG2E_Q32);
    n_q[0]   <= u[FR_W+N_W-1:FR_W];
    f_q[0]   <= u[FR_W-1:0];
    acc_q[0] <= ACC_W'(1) << FR_W;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fm_q    <= '0;
      fl_q[0] <= '0;
    end else begin
      fm_q    <= flags_i;
      fl_q[0] <= fm_q;
    end
  end

  for (genvar j = 0; j < FR_W; j++) begin : g_mul
    localparam logic [FR_W-1:0] CK = exp_root_c(j + 1);
    logic [PR_W-1:0] prod;
    logic [PR_W-1:0] rnd;

    assign prod = PR_W'(acc_q[j]) * PR_W'(CK);
    assign rnd  = prod + (PR_W'(1) << (FR_W - 1));

    always_ff @(posedge clk_i) begin
      acc_q[j+1] <= f_q[j][FR_W-1-j] ? rnd[PR_W-1:FR_W] : acc_q[j];
      f_q[j+1]   <= f_q[j];
      n_q[j+1]   <= n_q[j];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        fl_q[j+1] <= '0;
      end else begin
        fl_q[j+1] <= fl_q[j];
      end
    end
  end

  assign flags_o = fl_q[FR_W];
  assign acc_o   = acc_q[FR_W];
  assign n_o     = n_q[FR_W];

endmodule

FILE: rtl/gde_root.sv
// Normalizes v*2*pi to the top of a 64-bit word and takes its square root, one bit per stage.
// Depends on gde_pkg.
module gde_root (
  input  logic                            clk_i,
  input  logic [gde_pkg::DATA_WIDTH-1:0]  var_i,
  output logic [gde_pkg::ROOT_W-1:0]      r_o,
  output logic [gde_pkg::M_W-1:0]         m_o
);
  import gde_pkg::*;

  localparam int RM_W = ROOT_W + 2;
  localparam int RI_W = RM_W + 2;

  logic [X_W-1:0]    x_q   [0:NORM_STEPS];
  logic [M_W-1:0]    m_q   [0:NORM_STEPS];
  logic [RM_W-1:0]   rem_q [0:ROOT_W];
  logic [ROOT_W-1:0] rt_q  [0:ROOT_W];
  logic [X_W-1:0]    xs_q  [0:ROOT_W];
  logic [M_W-1:0]    ms_q  [0:ROOT_W];

  always_ff @(posedge clk_i) begin
    x_q[0] <= X_W'(var_i) * X_W'(TWO_PI_Q12);
    m_q[0] <= '0;
  end

  for (genvar i = 0; i < NORM_STEPS; i++) begin : g_norm
    localparam int SH = 2 << (NORM_STEPS - 1 - i);
    logic hit;
    assign hit = (x_q[i][X_W-1:X_W-SH] == '0);
    always_ff @(posedge clk_i) begin
      x_q[i+1] <= hit ? (x_q[i] << SH) : x_q[i];
      m_q[i+1] <= hit ? (m_q[i] | (M_W'(1) << (NORM_STEPS - 1 - i))) : m_q[i];
    end
  end

  assign rem_q[0] = '0;
  assign rt_q[0]  = '0;
  assign xs_q[0]  = x_q[NORM_STEPS];
  assign ms_q[0]  = m_q[NORM_STEPS];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    localparam int B = ROOT_W - 1 - j;
    logic [RI_W-1:0] rin;
    logic [RI_W-1:0] trial;
    logic            ge;

    assign rin   = {rem_q[j], xs_q[j][2*B+1:2*B]};
    assign trial = RI_W'({rt_q[j], 2'b01});
    assign ge    = rin >= trial;

    always_ff @(posedge clk_i) begin
      rem_q[j+1] <= ge ? RM_W'(rin - trial) : RM_W'(rin);
      rt_q[j+1]  <= {rt_q[j][ROOT_W-2:0], ge};
      xs_q[j+1]  <= xs_q[j];
      ms_q[j+1]  <= ms_q[j];
    end
  end

  assign r_o = rt_q[ROOT_W];
  assign m_o = ms_q[ROOT_W];

endmodule

FILE: rtl/gde_quot.sv
// Aligns 2^-frac against sqrt(2*pi*v) and divides with rounding, one quotient bit per stage.
// Depends on gde_pkg.
module gde_quot (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gde_pkg::flags_t              flags_i,
  input  logic [gde_pkg::ACC_W-1:0]    acc_i,
  input  logic [gde_pkg::N_W-1:0]      n_i,
  input  logic [gde_pkg::ROOT_W-1:0]   r_i,
  input  logic [gde_pkg::M_W-1:0]      m_i,
  output logic                         done_o,
  output logic [gde_pkg::DENS_W-1:0]   density_o,
  output logic                         bad_o,
  output logic                         sat_o
);
  import gde_pkg::*;

  localparam int NUM_W = 2 * ROOT_W;

  logic [S_W-1:0]    s;
  logic [S_W-1:0]    sa_q;
  logic [ACC_W-1:0]  acca_q;
  logic [ROOT_W-1:0] ra_q, rb_q;
  flags_t            fa_q, fb_q;
  logic [S_W-1:0]    sneg;
  logic [4:0]        k;
  logic [NUM_W-1:0]  acc64, r64, num;
  logic [NUM_W-1:0]  numb_q;

  logic [ROOT_W-1:0] rem_q [0:DENS_W];
  logic [DENS_W-1:0] q_q   [0:DENS_W];
  logic [ROOT_W-1:0] lo_q  [0:DENS_W];
  logic [ROOT_W-1:0] r_q   [0:DENS_W];
  logic              ov_q  [0:DENS_W];
  flags_t            f_q   [0:DENS_W];

  logic [DENS_W-1:0] dens_q;
  logic              done_q, bad_q, sat_q;

  assign s = S_W'(6) + S_W'(m_i) - S_W'(n_i);

  assign sneg  = -sa_q;
  assign k     = sneg[4:0];
  assign acc64 = NUM_W'(acca_q);
  assign r64   = NUM_W'(ra_q);

  // Shift the numerator up, or add half the divisor scaled by 2^k and shift the sum down by k
  always_comb begin
    if (!sa_q[S_W-1]) begin
      num = (acc64 << sa_q[4:0]) + NUM_W'(ra_q[ROOT_W-1:1]);
    end else begin
      num = (acc64 + (r64 << (k - 5'd1))) >> k;
    end
  end

  always_ff @(posedge clk_i) begin
    sa_q     <= s;
    acca_q   <= acc_i;
    ra_q     <= r_i;
    numb_q   <= num;
    rb_q     <= ra_q;
    rem_q[0] <= numb_q[NUM_W-1:ROOT_W];
    lo_q[0]  <= numb_q[ROOT_W-1:0];
    r_q[0]   <= rb_q;
    ov_q[0]  <= numb_q[NUM_W-1:ROOT_W] >= rb_q;
    q_q[0]   <= '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fa_q   <= '0;
      fb_q   <= '0;
      f_q[0] <= '0;
    end else begin
      // Drop anything scaled below 2^-31 of the divisor
      fa_q   <= '{valid: flags_i.valid, bad: flags_i.bad,
                  kill: (flags_i.kill | (s[S_W-1] & (s < S_W'(-31))))};
      fb_q   <= fa_q;
      f_q[0] <= fb_q;
    end
  end

  for (genvar j = 0; j < DENS_W; j++) begin : g_div
    localparam int B = DENS_W - 1 - j;
    logic [ROOT_W:0] rin;
    logic            ge;

    assign rin = {rem_q[j], lo_q[j][B]};
    assign ge  = rin >= {1'b0, r_q[j]};

    always_ff @(posedge clk_i) begin
      rem_q[j+1] <= ge ? ROOT_W'(rin - {1'b0, r_q[j]}) : ROOT_W'(rin);
      q_q[j+1]   <= {q_q[j][DENS_W-2:0], ge};
      lo_q[j+1]  <= lo_q[j];
      r_q[j+1]   <= r_q[j];
      ov_q[j+1]  <= ov_q[j];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        f_q[j+1] <= '0;
      end else begin
        f_q[j+1] <= f_q[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_q[DENS_W].kill) begin
      dens_q <= '0;
    end else if (ov_q[DENS_W]) begin
      dens_q <= DENS_MAX;
    end else begin
      dens_q <= q_q[DENS_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      bad_q  <= 1'b0;
      sat_q  <= 1'b0;
    end else begin
      done_q <= f_q[DENS_W].valid;
      bad_q  <= f_q[DENS_W].valid & f_q[DENS_W].bad;
      sat_q  <= f_q[DENS_W].valid & ~f_q[DENS_W].kill & ov_q[DENS_W];
    end
  end

  assign done_o    = done_q;
  assign density_o = dens_q;
  assign bad_o     = bad_q;
  assign sat_o     = sat_q;

endmodule

FILE: tb/tb_top.sv
// Self-checking bench for gaussian_density_eval_unit: directed and random density beats.
// Depends on gde_pkg and the unit RTL; predicts every result with its own fixed-point math.
`timescale 1ns / 1ps

module tb_top;

  localparam int CLK_HALF   = 6;
  localparam int DRAIN_CYC  = 140;
  localparam int RAND_ITEMS = 1750;

  typedef struct packed {
    logic [31:0] density;
    logic        bad_variance;
    logic        saturated;
  } density_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        start_i        = 1'b0;
  logic [31:0] observation_i  = '0;
  logic [31:0] mean_i         = '0;
  logic [31:0] variance_i     = '0;
  logic        busy_o;
  logic        done_o;
  logic [31:0] density_o;
  logic        bad_variance_o;
  logic        saturated_o;

  density_t density_q[$];
  int       mismatches = 0;

  gaussian_density_eval_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .observation_i  (observation_i),
    .mean_i         (mean_i),
    .variance_i     (variance_i),
    .done_o         (done_o),
    .density_o      (density_o),
    .bad_variance_o (bad_variance_o),
    .saturated_o    (saturated_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Floor square root, restoring digit by digit
  function automatic logic [63:0] floor_root(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = x;
    res  = '0;
    bitv = 64'h1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // exp(-(y-mu)^2/(2v)) / sqrt(2*pi*v) in Q8.24, plus the two flags
  function automatic density_t density_of(input logic [31:0] y, input logic [31:0] mu,
                                          input logic [31:0] v);
    density_t         res;
    logic signed [32:0] diff;
    logic [32:0]      mag;
    logic [127:0]     wide;
    logic [127:0]     ratio;
    logic [63:0]      frac;
    logic [63:0]      acc;
    logic [63:0]      c;
    logic [63:0]      x;
    logic [63:0]      root;
    logic [63:0]      num;
    logic [63:0]      den;
    logic [63:0]      q;
    int               n;
    int               m;
    int               s;
    res = '0;
    if (v == 0) begin
      res.bad_variance = 1'b1;
      return res;
    end
    diff  = $signed({y[31], y}) - $signed({mu[31], mu});
    mag   = diff[32] ? 33'(-diff) : 33'(diff);
    wide  = 128'(mag) * 128'(mag);
    ratio = (wide << 15) / 128'(v);
    // far tail: t >= 32 gives zero
    if (ratio >= (128'h1 << 37)) return res;
    wide = ratio * 128'h1_7154_7653;
    wide = wide >> 32;
    n    = int'(wide >> 32);
    frac = 64'(wide[31:0]);
    acc  = 64'h1 << 32;
    c    = 64'h1 << 31;
    for (int i = 31; i >= 0; i--) begin
      c = floor_root(c << 32);
      if (frac[i]) acc = (acc * c + (64'h1 << 31)) >> 32;
    end
    // normalize 2*pi*v to the top of the word before the root
    x = 64'(v) * 64'd25736;
    m = 0;
    while (x < (64'h1 << 62)) begin
      x = x << 2;
      m++;
    end
    root = floor_root(x);
    s = 6 + m - n;
    if (s < -31) return res;
    if (s >= 0) begin
      num = acc << s;
      den = root;
    end else begin
      num = acc;
      den = root << (-s);
    end
    q = (num + (den >> 1)) / den;
    if (q > 64'hFFFF_FFFF) begin
      res.density   = '1;
      res.saturated = 1'b1;
    end else begin
      res.density = q[31:0];
    end
    return res;
  endfunction

  // Drive one command beat and hold start high; the caller lowers it via pause_sender
  task automatic send_item(input logic [31:0] y, input logic [31:0] mu,
                           input logic [31:0] v);
    start_i       <= 1'b1;
    observation_i <= y;
    mean_i        <= mu;
    variance_i    <= v;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    density_q.push_back(density_of(y, mu, v));
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      start_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Compare every done beat against the oldest prediction
  always @(posedge clk_i) begin
    density_t want;
    if (rst_ni && done_o) begin
      if (density_q.size() == 0) begin
        $display("%0t: unexpected result density=%h bad=%b sat=%b", $time,
                 density_o, bad_variance_o, saturated_o);
        mismatches++;
      end else begin
        want = density_q.pop_front();
        if (density_o !== want.density) begin
          $display("%0t: density expected %h actual %h", $time, want.density, density_o);
          mismatches++;
        end
        if (bad_variance_o !== want.bad_variance) begin
          $display("%0t: bad_variance expected %b actual %b", $time,
                   want.bad_variance, bad_variance_o);
          mismatches++;
        end
        if (saturated_o !== want.saturated) begin
          $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                   saturated_o);
          mismatches++;
        end
      end
    end
  end

  // Field extremes, back to back
  task automatic test_extremes();
    send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
    send_item(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000);
    send_item(32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(32'h0000_0001, 32'h0000_0000, 32'h0000_0001);
    pause_sender(3);
  endtask

  // Zero variance raises the flag and forces density to zero
  task automatic test_zero_variance();
    send_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    send_item(32'h1234_5678, 32'h1234_5678, 32'h0000_0000);
    pause_sender(2);
  endtask

  // Far tail: t at or beyond 32 gives zero density; walk across the boundary too
  task automatic test_far_tail();
    send_item(32'h0010_0000, 32'h0000_0000, 32'h0000_0001);
    send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0100);
    send_item(32'h0008_0000, 32'h0000_0000, 32'h0001_0000);  // t = 32
    send_item(32'h0007_FFFF, 32'h0000_0000, 32'h0001_0000);  // just inside
    send_item(32'h0007_0000, 32'h0000_0000, 32'h0001_0000);
    send_item(32'hFFF9_0000, 32'h0000_0000, 32'h0001_0000);
    pause_sender(4);
  endtask

  // Random beats in bursts; deltas scaled so most land in the live part of the curve
  task automatic test_random();
    logic [31:0] y;
    logic [31:0] mu;
    logic [31:0] v;
    logic [31:0] delta;
    int          sent;
    int          burst;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && sent < RAND_ITEMS; k++) begin
        mu = $urandom;
        case ($urandom_range(0, 9))
          0: begin
            y = $urandom;
            v = $urandom;
          end
          1: begin
            y = $urandom;
            v = $urandom >> $urandom_range(0, 31);
          end
          default: begin
            v     = $urandom >> $urandom_range(0, 31);
            delta = $urandom >> $urandom_range(0, 31);
            y     = $urandom_range(0, 1) ? mu + delta : mu - delta;
          end
        endcase
        send_item(y, mu, v);
        sent++;
      end
      // about one burst in four runs straight into the next one
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
    end
    pause_sender(1);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_zero_variance();
    test_far_tail();
    test_random();
    while (density_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
